// File: hw/rtl/tpna_pkg.sv
// shared types and fixed widths for the triangle normal and area pipeline
// no dependencies
`timescale 1ns / 1ps

package tpna_pkg;

  localparam int COORD_W   = 20;
  localparam int SLOT_W    = 10;
  localparam int TAG_W     = 12;
  localparam int DIFF_W    = 21;
  localparam int PROD_W    = 42;
  localparam int CROSS_W   = 43;
  localparam int MAG_W     = 42;
  localparam int HALF_W    = 21;
  localparam int SQ_W      = 84;
  localparam int ROOT_W    = 43;
  localparam int RAD_W     = 86;
  localparam int REM_W     = 46;
  localparam int FRAC_BITS = 30;
  localparam int QUO_W     = 31;
  localparam int NORM_W    = 32;
  localparam int TERM_W    = 52;
  localparam int DOT_W     = 54;
  localparam int OFF_SHIFT = 14;
  localparam int OFF_W     = 37;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_SURFACE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t [2:0] mag3_t;

  // item data that rides along the long arithmetic stages
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    point_t           pa;
    logic [2:0]       neg;
    logic             deg;
  } side_t;

endpackage

// File: hw/rtl/tpna_store.sv
// point store: three copies of the point memory, one read port per vertex
// depends on tpna_pkg
`timescale 1ns / 1ps

module tpna_store import tpna_pkg::*; #(
  parameter int POINT_DEPTH = 1024,
  parameter int COORD_BITS  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  opcode_t                   opcode,
  input  logic [SLOT_W-1:0]         point_slot,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [SLOT_W-1:0]         vertex_a,
  input  logic [SLOT_W-1:0]         vertex_b,
  input  logic [SLOT_W-1:0]         vertex_c,
  input  logic [TAG_W-1:0]          surface_tag,
  output logic                      valid_o,
  output point_t                    pa,
  output point_t                    pb,
  output point_t                    pc,
  output logic [TAG_W-1:0]          tag_o
);

  localparam int AW      = $clog2(POINT_DEPTH);
  localparam int ENTRY_W = 3 * COORD_BITS;

  logic               accept;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [SLOT_W-1:0]  vslot [3];
  point_t             vert [3];
  logic               valid_r;
  logic [TAG_W-1:0]   tag_r;

  function automatic point_t unpack_point(input logic [ENTRY_W-1:0] e);
    point_t p;
    p.x = COORD_W'(signed'(e[3*COORD_BITS-1:2*COORD_BITS]));
    p.y = COORD_W'(signed'(e[2*COORD_BITS-1:COORD_BITS]));
    p.z = COORD_W'(signed'(e[COORD_BITS-1:0]));
    return p;
  endfunction

  assign accept  = in_valid && en;
  assign wr_en   = accept && (opcode == OP_LOAD) && (32'(point_slot) < POINT_DEPTH);
  assign wr_data = {coord_x[COORD_BITS-1:0], coord_y[COORD_BITS-1:0],
                    coord_z[COORD_BITS-1:0]};
  assign vslot[0] = vertex_a;
  assign vslot[1] = vertex_b;
  assign vslot[2] = vertex_c;

  for (genvar g = 0; g < 3; g++) begin : g_copy
    logic [ENTRY_W-1:0] mem [POINT_DEPTH];
    logic [ENTRY_W-1:0] rd_r;
    logic               ok_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[AW'(point_slot)] <= wr_data;
      end
      if (en) begin
        rd_r <= mem[AW'(vslot[g])];
        ok_r <= (32'(vslot[g]) < POINT_DEPTH);
      end
    end

    // slots beyond the store read as the origin
    assign vert[g] = ok_r ? unpack_point(rd_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= accept && (opcode == OP_SURFACE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= surface_tag;
    end
  end

  assign valid_o = valid_r;
  assign tag_o   = tag_r;
  assign pa      = vert[0];
  assign pb      = vert[1];
  assign pc      = vert[2];

endmodule

// File: hw/rtl/tpna_cross.sv
// edge vectors, cross product, component squares and squared length
// depends on tpna_pkg; also folds the tag into the surface range
`timescale 1ns / 1ps

module tpna_cross import tpna_pkg::*; #(
  parameter int MAX_SURFACES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  point_t           pa,
  input  point_t           pb,
  input  point_t           pc,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [SQ_W-1:0]  sq_o,
  output mag3_t            mag_o,
  output side_t            side_o
);

  localparam int TW = TAG_W + 17;

  function automatic logic [TAG_W-1:0] tag_step(input logic [TAG_W-1:0] t, input int j);
    logic [TW-1:0] w;
    logic [TW-1:0] m;
    w = TW'(t);
    m = TW'(MAX_SURFACES) << j;
    if (w >= m) begin
      w = w - m;
    end
    return TAG_W'(w);
  endfunction

  logic signed [COORD_W-1:0] ca [3];
  logic signed [COORD_W-1:0] cb [3];
  logic signed [COORD_W-1:0] cc [3];

  assign ca[0] = pa.x;
  assign ca[1] = pa.y;
  assign ca[2] = pa.z;
  assign cb[0] = pb.x;
  assign cb[1] = pb.y;
  assign cb[2] = pb.z;
  assign cc[0] = pc.x;
  assign cc[1] = pc.y;
  assign cc[2] = pc.z;

  logic [6:1]            v_r;
  point_t                pa_r [6:1];
  logic [TAG_W-1:0]      tag_r [6:1];
  logic signed [DIFF_W-1:0] d1_r [3];
  logic signed [DIFF_W-1:0] d2_r [3];
  logic signed [PROD_W-1:0] p_r [6];
  mag3_t                 mag3_r, mag4_r, mag5_r, mag6_r;
  logic [2:0]            neg3_r, neg4_r, neg5_r, neg6_r;
  logic                  deg4_r, deg5_r, deg6_r;
  logic [PROD_W-1:0]     hh_r [3];
  logic [PROD_W-1:0]     hl_r [3];
  logic [PROD_W-1:0]     ll_r [3];
  logic [SQ_W-1:0]       sq5_r [3];
  logic [SQ_W-1:0]       sum_r;
  mag3_t                 mag_m3, mag_m6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:1], valid_i};
    end
  end

  // tag folding: two restoring steps per stage
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[1]  <= pa;
      tag_r[1] <= tag_step(tag_step(tag_i, 11), 10);
      for (int k = 2; k <= 6; k++) begin
        pa_r[k]  <= pa_r[k-1];
        tag_r[k] <= tag_step(tag_step(tag_r[k-1], 13 - 2*k), 12 - 2*k);
      end
    end
  end

  // edges, cross products, magnitudes
  always_ff @(posedge clk) begin
    logic signed [CROSS_W-1:0] n;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DIFF_W'(ca[i]) - DIFF_W'(cb[i]);
        d2_r[i] <= DIFF_W'(ca[i]) - DIFF_W'(cc[i]);
      end
      p_r[0] <= PROD_W'(d1_r[1]) * PROD_W'(d2_r[2]);
      p_r[1] <= PROD_W'(d1_r[2]) * PROD_W'(d2_r[1]);
      p_r[2] <= PROD_W'(d1_r[2]) * PROD_W'(d2_r[0]);
      p_r[3] <= PROD_W'(d1_r[0]) * PROD_W'(d2_r[2]);
      p_r[4] <= PROD_W'(d1_r[0]) * PROD_W'(d2_r[1]);
      p_r[5] <= PROD_W'(d1_r[1]) * PROD_W'(d2_r[0]);
      for (int i = 0; i < 3; i++) begin
        n = CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
        neg3_r[i] <= n[CROSS_W-1];
        mag3_r[i] <= n[CROSS_W-1] ? MAG_W'(-n) : MAG_W'(n);
      end
    end
  end

  assign mag_m3 = mag3_r;

  // squares of 42-bit magnitudes from 21-bit halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= PROD_W'(mag_m3[i][MAG_W-1:HALF_W]) * PROD_W'(mag_m3[i][MAG_W-1:HALF_W]);
        hl_r[i] <= PROD_W'(mag_m3[i][MAG_W-1:HALF_W]) * PROD_W'(mag_m3[i][HALF_W-1:0]);
        ll_r[i] <= PROD_W'(mag_m3[i][HALF_W-1:0]) * PROD_W'(mag_m3[i][HALF_W-1:0]);
      end
      deg4_r <= (mag3_r == '0);
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= (SQ_W'(hh_r[i]) << (2*HALF_W)) + (SQ_W'(hl_r[i]) << (HALF_W + 1))
                    + SQ_W'(ll_r[i]);
      end
      deg5_r <= deg4_r;
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      sum_r  <= sq5_r[0] + sq5_r[1] + sq5_r[2];
      deg6_r <= deg5_r;
      mag6_r <= mag5_r;
      neg6_r <= neg5_r;
    end
  end

  assign mag_m6 = mag6_r;

  assign valid_o     = v_r[6];
  assign sq_o        = sum_r;
  assign mag_o       = mag_m6;
  assign side_o.tag  = tag_r[6];
  assign side_o.pa   = pa_r[6];
  assign side_o.neg  = neg6_r;
  assign side_o.deg  = deg6_r;

endmodule

// File: hw/rtl/tpna_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on tpna_pkg
`timescale 1ns / 1ps

module tpna_sqrt import tpna_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  mag3_t             mag_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output mag3_t             mag_o,
  output side_t             side_o
);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    mag3_t             mag;
    side_t             side;
  } sqrt_stage_t;

  sqrt_stage_t        st_in [ROOT_W];
  sqrt_stage_t        st_r  [ROOT_W];
  logic [ROOT_W-1:0]  v_r;

  always_comb begin
    st_in[0].rad  = RAD_W'(sq_i);
    st_in[0].rem  = '0;
    st_in[0].root = '0;
    st_in[0].mag  = mag_i;
    st_in[0].side = side_i;
    for (int k = 1; k < ROOT_W; k++) begin
      st_in[k] = st_r[k-1];
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    // bring down two radicand bits, try root*4+1
    assign cur   = {st_in[k].rem[REM_W-3:0], st_in[k].rad[RAD_W-1 -: 2]};
    assign trial = REM_W'({st_in[k].root, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k].rad  <= st_in[k].rad << 2;
        st_r[k].rem  <= ge ? (cur - trial) : cur;
        st_r[k].root <= {st_in[k].root[ROOT_W-2:0], ge};
        st_r[k].mag  <= st_in[k].mag;
        st_r[k].side <= st_in[k].side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-2:0], valid_i};
    end
  end

  assign valid_o = v_r[ROOT_W-1];
  assign root_o  = st_r[ROOT_W-1].root;
  assign mag_o   = st_r[ROOT_W-1].mag;
  assign side_o  = st_r[ROOT_W-1].side;

endmodule

// File: hw/rtl/tpna_div.sv
// three-lane pipelined restoring divider: magnitude * 2^30 / length
// depends on tpna_pkg
`timescale 1ns / 1ps

module tpna_div import tpna_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] den_i,
  input  mag3_t             num_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] den_o,
  output logic [QUO_W-1:0]  quo_o [3],
  output side_t             side_o
);

  localparam int NSTG = FRAC_BITS + 1;

  typedef struct packed {
    logic [ROOT_W-1:0]            den;
    logic [2:0][ROOT_W-1:0]       rem;
    logic [2:0][QUO_W-1:0]        quo;
    side_t                        side;
  } div_stage_t;

  div_stage_t       st_in [NSTG];
  div_stage_t       st_r  [NSTG];
  logic [NSTG-1:0]  v_r;

  always_comb begin
    st_in[0].den  = den_i;
    st_in[0].quo  = '0;
    st_in[0].side = side_i;
    for (int i = 0; i < 3; i++) begin
      st_in[0].rem[i] = ROOT_W'(num_i[i]);
    end
    for (int k = 1; k < NSTG; k++) begin
      st_in[k] = st_r[k-1];
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [ROOT_W:0] sh;
      logic            ge;

      // first stage gives the integer bit, the rest one fraction bit each
      if (k == 0) begin : g_int
        assign sh = {1'b0, st_in[k].rem[i]};
      end else begin : g_frac
        assign sh = {st_in[k].rem[i], 1'b0};
      end
      assign ge = (sh >= {1'b0, st_in[k].den});

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[k].rem[i] <= ge ? ROOT_W'(sh - {1'b0, st_in[k].den}) : ROOT_W'(sh);
          st_r[k].quo[i] <= {st_in[k].quo[i][QUO_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k].den  <= st_in[k].den;
        st_r[k].side <= st_in[k].side;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], valid_i};
    end
  end

  assign valid_o = v_r[NSTG-1];
  assign den_o   = st_r[NSTG-1].den;
  assign side_o  = st_r[NSTG-1].side;
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign quo_o[i] = st_r[NSTG-1].quo[i];
  end

endmodule

// File: hw/rtl/triangle_plane_normal_area.sv
// pipeline from input beat to result beat: store read, cross, root, divide, normal/offset;
// one surface or point beat accepted every cycle while the result beat is not stalled
// a stalled result beat freezes the whole pipeline in place until it is taken
// synchronous active-low reset clears all valid bits; point memory contents are kept
// point store: three copies of the point memory; depends on tpna_pkg and all tpna_ modules
`timescale 1ns / 1ps

module triangle_plane_normal_area import tpna_pkg::*; #(
  parameter int POINT_DEPTH  = 1024,
  parameter int COORD_BITS   = 20,
  parameter int MAX_SURFACES = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [SLOT_W-1:0]         in_point_slot,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [SLOT_W-1:0]         in_vertex_a,
  input  logic [SLOT_W-1:0]         in_vertex_b,
  input  logic [SLOT_W-1:0]         in_vertex_c,
  input  logic [TAG_W-1:0]          in_surface_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [TAG_W-1:0]          out_result_tag,
  output logic signed [NORM_W-1:0]  out_normal_x,
  output logic signed [NORM_W-1:0]  out_normal_y,
  output logic signed [NORM_W-1:0]  out_normal_z,
  output logic [ROOT_W-1:0]         out_twice_area,
  output logic signed [OFF_W-1:0]   out_plane_offset,
  output logic                      out_degenerate
);

  logic              en;
  logic              st_valid;
  point_t            st_pa, st_pb, st_pc;
  logic [TAG_W-1:0]  st_tag;
  logic              cr_valid;
  logic [SQ_W-1:0]   cr_sq;
  mag3_t             cr_mag;
  side_t             cr_side;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  mag3_t             sq_mag;
  side_t             sq_side;
  logic              dv_valid;
  logic [ROOT_W-1:0] dv_den;
  logic [QUO_W-1:0]  dv_quo [3];
  side_t             dv_side;

  logic                      t1_valid_r, t2_valid_r, out_valid_r;
  logic signed [NORM_W-1:0]  nq_r [3];
  logic signed [NORM_W-1:0]  nq2_r [3];
  logic signed [TERM_W-1:0]  term_r [3];
  side_t                     t1_side_r, t2_side_r;
  logic [ROOT_W-1:0]         len1_r, len2_r;
  logic signed [COORD_W-1:0] pa_c [3];
  logic signed [DOT_W-1:0]   neg_dot;

  logic [TAG_W-1:0]          tag_r;
  logic signed [NORM_W-1:0]  nx_r, ny_r, nz_r;
  logic [ROOT_W-1:0]         area_r;
  logic signed [OFF_W-1:0]   off_r;
  logic                      deg_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tpna_store #(
    .POINT_DEPTH (POINT_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .opcode      (opcode_t'(in_opcode)),
    .point_slot  (in_point_slot),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .coord_z     (in_coord_z),
    .vertex_a    (in_vertex_a),
    .vertex_b    (in_vertex_b),
    .vertex_c    (in_vertex_c),
    .surface_tag (in_surface_tag),
    .valid_o     (st_valid),
    .pa          (st_pa),
    .pb          (st_pb),
    .pc          (st_pc),
    .tag_o       (st_tag)
  );

  tpna_cross #(
    .MAX_SURFACES (MAX_SURFACES)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (st_valid),
    .pa      (st_pa),
    .pb      (st_pb),
    .pc      (st_pc),
    .tag_i   (st_tag),
    .valid_o (cr_valid),
    .sq_o    (cr_sq),
    .mag_o   (cr_mag),
    .side_o  (cr_side)
  );

  tpna_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (cr_valid),
    .sq_i    (cr_sq),
    .mag_i   (cr_mag),
    .side_i  (cr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .mag_o   (sq_mag),
    .side_o  (sq_side)
  );

  tpna_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_valid),
    .den_i   (sq_root),
    .num_i   (sq_mag),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .den_o   (dv_den),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  assign pa_c[0] = t1_side_r.pa.x;
  assign pa_c[1] = t1_side_r.pa.y;
  assign pa_c[2] = t1_side_r.pa.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_valid_r  <= 1'b0;
      t2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      t1_valid_r  <= dv_valid;
      t2_valid_r  <= t1_valid_r;
      out_valid_r <= t2_valid_r;
    end
  end

  // apply the cross product signs, then vertex one times normal
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nq_r[i]   <= dv_side.neg[i] ? -NORM_W'(dv_quo[i]) : NORM_W'(dv_quo[i]);
        nq2_r[i]  <= nq_r[i];
        term_r[i] <= TERM_W'(pa_c[i]) * TERM_W'(nq_r[i]);
      end
      t1_side_r <= dv_side;
      len1_r    <= dv_den;
      t2_side_r <= t1_side_r;
      len2_r    <= len1_r;
    end
  end

  assign neg_dot = -(DOT_W'(term_r[0]) + DOT_W'(term_r[1]) + DOT_W'(term_r[2]));

  // result register; degenerate triangles give zero normal, area and offset
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r  <= t2_side_r.tag;
      deg_r  <= t2_side_r.deg;
      nx_r   <= t2_side_r.deg ? '0 : nq2_r[0];
      ny_r   <= t2_side_r.deg ? '0 : nq2_r[1];
      nz_r   <= t2_side_r.deg ? '0 : nq2_r[2];
      area_r <= t2_side_r.deg ? '0 : len2_r;
      off_r  <= t2_side_r.deg ? '0 : OFF_W'(neg_dot >>> OFF_SHIFT);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_tag   = tag_r;
  assign out_normal_x     = nx_r;
  assign out_normal_y     = ny_r;
  assign out_normal_z     = nz_r;
  assign out_twice_area   = area_r;
  assign out_plane_offset = off_r;
  assign out_degenerate   = deg_r;

endmodule
